/* rtl/core/fsp_pkg.sv */
// ----------------------------------------------------------------------------
// fsp_pkg
// Types, character codes and decode functions of the format spec parser.
// ----------------------------------------------------------------------------
`default_nettype none

package fsp_pkg;

    // Saturation limits of the numeric fields
    localparam logic [16:0] WIDTH_CAP = 17'd100000;
    localparam logic [9:0]  PREC_CAP  = 10'd1000;

    // Command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Lookahead store: lead byte plus up to three trailing bytes plus align byte
    localparam int LA_DEPTH = 5;

    // Character codes
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_D      = 8'h64;
    localparam logic [7:0] CH_X_LO   = 8'h78;
    localparam logic [7:0] CH_X_UP   = 8'h58;
    localparam logic [7:0] CH_O      = 8'h6F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_PCT    = 8'h25;

    // UTF-8 lead byte prefixes
    localparam logic [7:0] UTF_ASCII_LIMIT = 8'h80;
    localparam logic [2:0] UTF_LEAD2       = 3'd6;
    localparam logic [3:0] UTF_LEAD3       = 4'd14;
    localparam logic [4:0] UTF_LEAD4       = 5'd30;

    // Result codes
    localparam logic [2:0] ALIGN_NONE   = 3'd0;
    localparam logic [2:0] ALIGN_LEFT   = 3'd1;
    localparam logic [2:0] ALIGN_RIGHT  = 3'd2;
    localparam logic [2:0] ALIGN_CENTER = 3'd3;
    localparam logic [2:0] ALIGN_PAD    = 3'd4;

    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_PLUS  = 2'd1;
    localparam logic [1:0] SIGN_MINUS = 2'd2;

    localparam logic [3:0] TYPE_NONE  = 4'd0;
    localparam logic [3:0] TYPE_F     = 4'd1;
    localparam logic [3:0] TYPE_E     = 4'd2;
    localparam logic [3:0] TYPE_D     = 4'd3;
    localparam logic [3:0] TYPE_X_LO  = 4'd4;
    localparam logic [3:0] TYPE_X_UP  = 4'd5;
    localparam logic [3:0] TYPE_O     = 4'd6;
    localparam logic [3:0] TYPE_B     = 4'd7;
    localparam logic [3:0] TYPE_S     = 4'd8;
    localparam logic [3:0] TYPE_PCT   = 4'd9;

    typedef enum logic [1:0] {
        OP_BYTE,
        OP_FILL,
        OP_END,
        OP_END_EMPTY
    } t_op;

    // One queued command; data holds the byte (low 8 bits) or the fill bytes
    typedef struct packed {
        t_op         op;
        logic [31:0] data;
        logic [2:0]  fill_len;
        logic [2:0]  align;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        FR_COLLECT,
        FR_PASS,
        FR_REPLAY
    } t_front_state;

    typedef enum logic [3:0] {
        PH_ALIGN,
        PH_SIGN,
        PH_ZERO,
        PH_WIDTH,
        PH_COMMA,
        PH_DOT,
        PH_PREC_FIRST,
        PH_PREC,
        PH_TYPE,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic        spec_valid;
        logic [31:0] fill_bytes;
        logic [2:0]  fill_length;
        logic [2:0]  align_mode;
        logic [1:0]  sign_mode;
        logic        zero_flag;
        logic [16:0] field_width;
        logic        comma_flag;
        logic        has_precision;
        logic [9:0]  precision_value;
        logic [3:0]  type_code;
    } t_result;

    function automatic logic [2:0] lead_length(input logic [7:0] c);
        logic [2:0] len;
        if (c < UTF_ASCII_LIMIT) begin
            len = 3'd1;
        end else if (c[7:5] == UTF_LEAD2) begin
            len = 3'd2;
        end else if (c[7:4] == UTF_LEAD3) begin
            len = 3'd3;
        end else if (c[7:3] == UTF_LEAD4) begin
            len = 3'd4;
        end else begin
            len = 3'd1;
        end
        return len;
    endfunction

    function automatic logic [2:0] align_code(input logic [7:0] c);
        logic [2:0] code;
        unique case (c)
            CH_LT:    code = ALIGN_LEFT;
            CH_GT:    code = ALIGN_RIGHT;
            CH_CARET: code = ALIGN_CENTER;
            CH_EQ:    code = ALIGN_PAD;
            default:  code = ALIGN_NONE;
        endcase
        return code;
    endfunction

    function automatic logic [3:0] type_code(input logic [7:0] c);
        logic [3:0] code;
        unique case (c)
            CH_F:    code = TYPE_F;
            CH_E:    code = TYPE_E;
            CH_D:    code = TYPE_D;
            CH_X_LO: code = TYPE_X_LO;
            CH_X_UP: code = TYPE_X_UP;
            CH_O:    code = TYPE_O;
            CH_B:    code = TYPE_B;
            CH_S:    code = TYPE_S;
            CH_PCT:  code = TYPE_PCT;
            default: code = TYPE_NONE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/fsp_queue.sv */
// ----------------------------------------------------------------------------
// fsp_queue
// Short command queue between the parser front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_queue
    import fsp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_cmd      i_cmd,
    input  wire logic      i_pop,
    output t_cmd           o_cmd,
    output t_q_status      o_status
);

    t_cmd              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_AW:0]     r_count;

    logic              push_ok;
    logic              pop_ok;

    assign o_status.full  = (r_count == Q_DEPTH[Q_AW:0]);
    assign o_status.empty = (r_count == '0);
    assign push_ok        = i_push && !o_status.full;
    assign pop_ok         = i_pop && !o_status.empty;
    assign o_cmd          = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/core/fsp_front.sv */
// ----------------------------------------------------------------------------
// fsp_front
// Accept words, collect the fill lookahead and turn it into queue commands.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_front
    import fsp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_is_end,
    input  wire logic [7:0] i_byte,
    input  wire t_q_status  i_q_status,
    output logic            o_push,
    output t_cmd            o_cmd
);

    t_front_state r_state, n_state;
    logic [7:0]   r_la [LA_DEPTH];
    logic [2:0]   r_count, n_count;
    logic [2:0]   r_lead, n_lead;
    logic [2:0]   r_idx, n_idx;
    logic         r_end_pend, n_end_pend;

    logic         acc;
    logic         la_we;
    logic [2:0]   lead_now;
    logic         test_hit;
    logic         fill_ok;
    logic [31:0]  fill_word;

    assign acc      = i_valid && o_ready;
    assign lead_now = (r_count == 3'd0) ? lead_length(i_byte) : r_lead;
    assign test_hit = (r_count >= lead_now);
    assign fill_ok  = (r_la[0] != CH_LBRACE) && (r_la[0] != CH_RBRACE)
                      && (align_code(i_byte) != ALIGN_NONE);
    assign la_we    = acc && !i_is_end && (r_state == FR_COLLECT);

    // Fill bytes already sit at indexes 0 .. lead-1 when the test fires
    assign fill_word = {(r_lead > 3'd3) ? r_la[3] : 8'h00,
                        (r_lead > 3'd2) ? r_la[2] : 8'h00,
                        (r_lead > 3'd1) ? r_la[1] : 8'h00,
                        r_la[0]};

    // Next state
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_lead     = r_lead;
        n_idx      = r_idx;
        n_end_pend = r_end_pend;
        unique case (r_state)
            FR_COLLECT: begin
                if (acc) begin
                    if (i_is_end) begin
                        if (r_count != 3'd0) begin
                            n_state    = FR_REPLAY;
                            n_idx      = 3'd0;
                            n_end_pend = 1'b1;
                        end
                    end else begin
                        n_count = r_count + 1'b1;
                        n_lead  = lead_now;
                        if (test_hit) begin
                            n_idx      = 3'd0;
                            n_end_pend = 1'b0;
                            n_state    = fill_ok ? FR_PASS : FR_REPLAY;
                        end
                    end
                end
            end
            FR_PASS: begin
                if (acc && i_is_end) begin
                    n_state = FR_COLLECT;
                    n_count = 3'd0;
                end
            end
            FR_REPLAY: begin
                if (r_idx != r_count) begin
                    if (!i_q_status.full) begin
                        n_idx = r_idx + 1'b1;
                    end
                end else if (r_end_pend) begin
                    if (!i_q_status.full) begin
                        n_state = FR_COLLECT;
                        n_count = 3'd0;
                    end
                end else begin
                    n_state = FR_PASS;
                end
            end
            default: n_state = FR_COLLECT;
        endcase
    end

    // Outputs
    always_comb begin
        o_ready       = 1'b0;
        o_push        = 1'b0;
        o_cmd.op      = OP_BYTE;
        o_cmd.data    = {24'd0, i_byte};
        o_cmd.fill_len = r_lead;
        o_cmd.align   = align_code(i_byte);
        unique case (r_state)
            FR_COLLECT: begin
                o_ready = !i_q_status.full;
                if (acc) begin
                    if (i_is_end) begin
                        if (r_count == 3'd0) begin
                            o_push   = 1'b1;
                            o_cmd.op = OP_END_EMPTY;
                        end
                    end else if (test_hit && fill_ok) begin
                        o_push     = 1'b1;
                        o_cmd.op   = OP_FILL;
                        o_cmd.data = fill_word;
                    end
                end
            end
            FR_PASS: begin
                o_ready = !i_q_status.full;
                if (acc) begin
                    o_push   = 1'b1;
                    o_cmd.op = i_is_end ? OP_END : OP_BYTE;
                end
            end
            FR_REPLAY: begin
                if (r_idx != r_count) begin
                    o_push     = !i_q_status.full;
                    o_cmd.data = {24'd0, r_la[r_idx]};
                end else if (r_end_pend) begin
                    o_push   = !i_q_status.full;
                    o_cmd.op = OP_END;
                end
            end
            default: o_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (la_we) begin
            r_la[r_count] <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= FR_COLLECT;
            r_count    <= 3'd0;
            r_lead     <= 3'd0;
            r_idx      <= 3'd0;
            r_end_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_lead     <= n_lead;
            r_idx      <= n_idx;
            r_end_pend <= n_end_pend;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/fsp_back.sv */
// ----------------------------------------------------------------------------
// fsp_back
// Run queued commands through the spec grammar and register the result.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_back
    import fsp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cmd      i_cmd,
    input  wire t_q_status i_q_status,
    output logic           o_pop,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_result        o_result
);

    t_phase      r_phase, n_phase;
    logic        r_err, n_err;
    logic [31:0] r_fill, n_fill;
    logic [2:0]  r_fill_len, n_fill_len;
    logic [2:0]  r_align, n_align;
    logic [1:0]  r_sign, n_sign;
    logic        r_zero, n_zero;
    logic [16:0] r_width, n_width;
    logic        r_comma, n_comma;
    logic        r_has_prec, n_has_prec;
    logic [9:0]  r_prec, n_prec;
    logic [3:0]  r_type, n_type;
    logic        r_out_valid;
    t_result     r_out, n_out;

    logic        is_end;
    logic        pop_end;
    logic        done;
    logic [7:0]  b;
    logic        is_digit;
    logic [20:0] w_sum;
    logic [13:0] p_sum;
    logic        spec_ok;

    assign b        = i_cmd.data[7:0];
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign is_end   = (i_cmd.op == OP_END) || (i_cmd.op == OP_END_EMPTY);
    assign o_pop    = !i_q_status.empty && (!is_end || !r_out_valid || i_ready);
    assign pop_end  = o_pop && is_end;

    // acc * 10 + digit
    assign w_sum = ({4'd0, r_width} << 3) + ({4'd0, r_width} << 1) + {17'd0, b[3:0]};
    assign p_sum = ({4'd0, r_prec} << 3) + ({4'd0, r_prec} << 1) + {10'd0, b[3:0]};

    assign spec_ok = (i_cmd.op == OP_END) && !r_err && (r_phase != PH_PREC_FIRST);

    // Grammar step: fall through optional parts until the byte is consumed
    always_comb begin
        n_phase    = r_phase;
        n_err      = r_err;
        n_fill     = r_fill;
        n_fill_len = r_fill_len;
        n_align    = r_align;
        n_sign     = r_sign;
        n_zero     = r_zero;
        n_width    = r_width;
        n_comma    = r_comma;
        n_has_prec = r_has_prec;
        n_prec     = r_prec;
        n_type     = r_type;
        done       = 1'b0;
        unique case (i_cmd.op)
            OP_FILL: begin
                n_fill     = i_cmd.data;
                n_fill_len = i_cmd.fill_len;
                n_align    = i_cmd.align;
                n_phase    = PH_SIGN;
            end
            OP_BYTE: begin
                if (!r_err) begin
                    if (n_phase == PH_ALIGN) begin
                        n_phase = PH_SIGN;
                        if (align_code(b) != ALIGN_NONE) begin
                            n_align = align_code(b);
                            done    = 1'b1;
                        end
                    end
                    if (!done && n_phase == PH_SIGN) begin
                        n_phase = PH_ZERO;
                        if (b == CH_PLUS) begin
                            n_sign = SIGN_PLUS;
                            done   = 1'b1;
                        end else if (b == CH_MINUS) begin
                            n_sign = SIGN_MINUS;
                            done   = 1'b1;
                        end
                    end
                    if (!done && n_phase == PH_ZERO) begin
                        n_phase = PH_WIDTH;
                        if (b == CH_ZERO) begin
                            n_zero = 1'b1;
                            done   = 1'b1;
                        end
                    end
                    if (!done && n_phase == PH_WIDTH) begin
                        if (is_digit) begin
                            n_width = (w_sum > {4'd0, WIDTH_CAP}) ? WIDTH_CAP : w_sum[16:0];
                            done    = 1'b1;
                        end else begin
                            n_phase = PH_COMMA;
                        end
                    end
                    if (!done && n_phase == PH_COMMA) begin
                        n_phase = PH_DOT;
                        if (b == CH_COMMA) begin
                            n_comma = 1'b1;
                            done    = 1'b1;
                        end
                    end
                    if (!done && n_phase == PH_DOT) begin
                        if (b == CH_DOT) begin
                            n_phase = PH_PREC_FIRST;
                            done    = 1'b1;
                        end else begin
                            n_phase = PH_TYPE;
                        end
                    end
                    if (!done && (n_phase == PH_PREC_FIRST || n_phase == PH_PREC)) begin
                        if (is_digit) begin
                            n_prec     = (p_sum > {4'd0, PREC_CAP}) ? PREC_CAP : p_sum[9:0];
                            n_has_prec = 1'b1;
                            n_phase    = PH_PREC;
                            done       = 1'b1;
                        end else if (n_phase == PH_PREC_FIRST) begin
                            n_err = 1'b1;
                            done  = 1'b1;
                        end else begin
                            n_phase = PH_TYPE;
                        end
                    end
                    if (!done && n_phase == PH_TYPE) begin
                        done = 1'b1;
                        if (type_code(b) != TYPE_NONE) begin
                            n_type  = type_code(b);
                            n_phase = PH_DONE;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    // Any byte after the type is an error
                    if (!done && n_phase == PH_DONE) begin
                        n_err = 1'b1;
                    end
                end
            end
            OP_END, OP_END_EMPTY: begin
                n_phase    = PH_ALIGN;
                n_err      = 1'b0;
                n_fill     = '0;
                n_fill_len = '0;
                n_align    = ALIGN_NONE;
                n_sign     = SIGN_NONE;
                n_zero     = 1'b0;
                n_width    = '0;
                n_comma    = 1'b0;
                n_has_prec = 1'b0;
                n_prec     = '0;
                n_type     = TYPE_NONE;
            end
            default: n_phase = r_phase;
        endcase
    end

    // Result word, all zero (spec_valid too) when the spec is bad
    always_comb begin
        n_out = '0;
        if (spec_ok) begin
            n_out.spec_valid      = 1'b1;
            n_out.fill_bytes      = r_fill;
            n_out.fill_length     = r_fill_len;
            n_out.align_mode      = r_align;
            n_out.sign_mode       = r_sign;
            n_out.zero_flag       = r_zero;
            n_out.field_width     = r_width;
            n_out.comma_flag      = r_comma;
            n_out.has_precision   = r_has_prec;
            n_out.precision_value = r_prec;
            n_out.type_code       = r_type;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (pop_end) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_ALIGN;
            r_err       <= 1'b0;
            r_fill      <= '0;
            r_fill_len  <= '0;
            r_align     <= ALIGN_NONE;
            r_sign      <= SIGN_NONE;
            r_zero      <= 1'b0;
            r_width     <= '0;
            r_comma     <= 1'b0;
            r_has_prec  <= 1'b0;
            r_prec      <= '0;
            r_type      <= TYPE_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase    <= n_phase;
                r_err      <= n_err;
                r_fill     <= n_fill;
                r_fill_len <= n_fill_len;
                r_align    <= n_align;
                r_sign     <= n_sign;
                r_zero     <= n_zero;
                r_width    <= n_width;
                r_comma    <= n_comma;
                r_has_prec <= n_has_prec;
                r_prec     <= n_prec;
                r_type     <= n_type;
            end
            if (pop_end) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/format_spec_parser_top.sv */
// ----------------------------------------------------------------------------
// format_spec_parser_top
// Format spec parser: bytes of a spec in, one parsed result per end word out.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle; a lookahead replay (failed fill test, or an
//   end word inside the lookahead) stalls input while the held bytes are
//   replayed; a full queue behind a held result also stalls input.
// Result path: an end word is pushed into the queue, popped by the back and
//   its result registered as o_m_tvalid rises.
// Reset: i_rst_n synchronous, active low; clears the front, queue and back,
//   the block is ready for words as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module format_spec_parser_top
    import fsp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input words
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] char_byte
    input  wire logic        i_s_tuser,   // [0] kind (1 = end of spec)
    // Result words
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [31:0] fill_bytes, [34:32] fill_length, [37:35] align_mode,
    // [39:38] sign_mode, [40] zero_flag, [57:41] field_width,
    // [58] comma_flag, [59] has_precision, [69:60] precision_value,
    // [73:70] type_code, [79:74] zero
    output logic [79:0]      o_m_tdata,
    output logic             o_m_tuser    // [0] spec_valid
);

    // Front to queue
    logic      front_push;
    t_cmd      front_cmd;

    // Queue to back
    t_cmd      q_cmd;
    t_q_status q_status;
    logic      back_pop;

    t_result   result;

    // Front: accept words, hold the fill lookahead, replay it on a failed fill test
    // or an end word in it, and hand one command per cycle to the queue while not full.
    fsp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_is_end   (i_s_tuser),
        .i_byte     (i_s_tdata),
        .i_q_status (q_status),
        .o_push     (front_push),
        .o_cmd      (front_cmd)
    );

    // Short queue lets the front keep taking words while the back waits
    // on a stalled result word.
    fsp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (front_push),
        .i_cmd    (front_cmd),
        .i_pop    (back_pop),
        .o_cmd    (q_cmd),
        .o_status (q_status)
    );

    // Back: step grammar one command per cycle, register result; a held one stalls ends.
    fsp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (q_cmd),
        .i_q_status (q_status),
        .o_pop      (back_pop),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_result   (result)
    );

    // Pack the result fields, fill_bytes in the lowest bits
    assign o_m_tuser = result.spec_valid;
    assign o_m_tdata = {6'd0,
                        result.type_code,
                        result.precision_value,
                        result.has_precision,
                        result.comma_flag,
                        result.field_width,
                        result.zero_flag,
                        result.sign_mode,
                        result.align_mode,
                        result.fill_length,
                        result.fill_bytes};

endmodule

`default_nettype wire
